// ===== sv/kce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kce_pkg: shared types and constants for the keypad code entry unit
// Channel payloads, screen codes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package kce_pkg;

	localparam int CODE_LENGTH_DEF = 6;
	localparam int CFG_W           = 16;

	localparam logic [15:0] TIMEOUT_RST = 16'd5000;
	localparam logic [7:0]  ERASE_RST   = 8'd35;
	localparam logic [7:0]  ENTER_RST   = 8'd42;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_TIMEOUT = 2'd0;
	localparam cfg_idx_t CFG_ERASE   = 2'd1;
	localparam cfg_idx_t CFG_ENTER   = 2'd2;

	typedef enum logic [2:0] {
		SCR_START      = 3'd0,
		SCR_ADDED      = 3'd1,
		SCR_ERASED     = 3'd2,
		SCR_SEARCH     = 3'd3,
		SCR_INCOMPLETE = 3'd4,
		SCR_IDLE       = 3'd5,
		SCR_TIMEOUT    = 3'd6
	} screen_e;

	typedef enum logic [2:0] {
		ST_FIRST,
		ST_COLLECT,
		ST_SEARCH,
		ST_CLEAR,
		ST_EMIT
	} state_e;

	typedef struct packed {
		logic [7:0]  key;
		logic [31:0] time_now;
	} kce_in_t;

	typedef struct packed {
		logic [2:0] screen;
		logic       code_valid;
		logic [7:0] code_byte;
		logic       last;
	} kce_out_t;

	typedef struct packed {
		logic    ready;
		logic    take;
		logic    out_load;
		screen_e screen;
		logic    out_code;
		logic    out_last;
		logic    add_key;
		logic    del_key;
		logic    clear_fill;
		logic    touch_time;
		logic    idx_start;
		logic    idx_step;
	} kce_cmd_t;

	typedef struct packed {
		logic poll_valid;
		logic key_none;
		logic key_erase;
		logic key_enter;
		logic expired;
		logic full;
		logic fill_one;
		logic emit_last;
		logic out_free;
	} kce_sts_t;

endpackage
`default_nettype wire

// ===== sv/keypad_code_entry_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_code_entry_unit: keypad code entry controller
// Collects a fixed-length key code with erase, enter and inactivity timeout,
// and dumps the confirmed code one byte per result.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  poll     | poll_valid/poll_stall  | kce_in_t  {key, time_now}
//  res      | res_valid/res_stall    | kce_out_t {screen, code_valid, code_byte, last}
//  config   | cfg_we                 | cfg_idx, cfg_data
//
// A poll that is not a dump trigger yields one result. A dump trigger poll
// starts the dump: the store is sent one byte per cycle while the result
// register is free, CODE_LENGTH results in all; no poll is taken meanwhile.
// The single result register sets the pace: outside a dump trigger, a poll
// is taken only when it is empty or its result transfers in the same cycle.
// The dump trigger poll is taken even while the result register is full.
// Reset restores the register defaults and an empty code; no clearing pass.
// ----------------------------------------------------------------------------
module keypad_code_entry_unit import kce_pkg::*; #(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire cfg_idx_t   cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic       poll_valid,
	output logic            poll_stall,
	input  wire kce_in_t    poll,
	output logic            res_valid,
	input  wire logic       res_stall,
	output kce_out_t        res
);

	kce_cmd_t cmd;
	kce_sts_t sts;

	kce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	kce_dp #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.poll_valid (poll_valid),
		.poll       (poll),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cmd        (cmd),
		.sts        (sts)
	);

	assign poll_stall = !cmd.ready;

`ifndef NO_ASSERTIONS
	a_code_screen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.code_valid |-> res.screen == SCR_START)
		else $error("code byte result without start screen");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten before transfer");

	a_dump_holds_poll: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.code_valid && !res.last |-> !cmd.take)
		else $error("poll taken in the middle of a code dump");
`endif

endmodule
`default_nettype wire

// ===== sv/kce_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kce_ctrl: entry sequencer
// Walks the entry phases and drives the datapath with one command group
// per cycle from the datapath status.
// ----------------------------------------------------------------------------
module kce_ctrl import kce_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire kce_sts_t sts,
	output kce_cmd_t      cmd
);

	state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FIRST;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.screen   = SCR_START;
		cmd.out_last = 1'b1;
		state_d  = state_q;
		unique case (state_q)
			ST_FIRST: begin
				cmd.ready = sts.out_free;
				cmd.take  = cmd.ready & sts.poll_valid;
				if (cmd.take) begin
					cmd.out_load = 1'b1;
					priority if (sts.key_none) begin
						cmd.screen = SCR_START;
					end else if (sts.key_erase || sts.key_enter) begin
						cmd.screen = SCR_IDLE;
					end else begin
						cmd.screen     = SCR_ADDED;
						cmd.add_key    = 1'b1;
						cmd.touch_time = 1'b1;
						state_d        = ST_COLLECT;
					end
				end
			end
			ST_COLLECT: begin
				cmd.ready = sts.out_free;
				cmd.take  = cmd.ready & sts.poll_valid;
				if (cmd.take) begin
					cmd.out_load = 1'b1;
					priority if (sts.expired) begin
						cmd.screen = SCR_TIMEOUT;
						state_d    = ST_CLEAR;
					end else if (sts.key_none) begin
						cmd.screen = SCR_IDLE;
					end else if (sts.key_erase) begin
						cmd.screen     = SCR_ERASED;
						cmd.del_key    = 1'b1;
						cmd.touch_time = 1'b1;
						if (sts.fill_one) begin
							state_d = ST_FIRST;
						end
					end else if (sts.key_enter) begin
						if (sts.full) begin
							cmd.screen = SCR_SEARCH;
							state_d    = ST_SEARCH;
						end else begin
							cmd.screen = SCR_INCOMPLETE;
							state_d    = ST_CLEAR;
						end
					end else if (!sts.full) begin
						cmd.screen     = SCR_ADDED;
						cmd.add_key    = 1'b1;
						cmd.touch_time = 1'b1;
					end else begin
						cmd.screen = SCR_IDLE;
					end
				end
			end
			ST_CLEAR: begin
				cmd.ready = sts.out_free;
				cmd.take  = cmd.ready & sts.poll_valid;
				if (cmd.take) begin
					cmd.out_load   = 1'b1;
					cmd.clear_fill = 1'b1;
					state_d        = ST_FIRST;
				end
			end
			ST_SEARCH: begin
				// the poll only triggers the dump; its key is dropped
				cmd.ready = 1'b1;
				cmd.take  = sts.poll_valid;
				if (cmd.take) begin
					cmd.idx_start = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_code = 1'b1;
					cmd.out_last = sts.emit_last;
					cmd.idx_step = 1'b1;
					if (sts.emit_last) begin
						cmd.clear_fill = 1'b1;
						state_d        = ST_FIRST;
					end
				end
			end
			default: begin
				state_d = ST_FIRST;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/kce_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kce_dp: entry datapath
// Configuration registers, key store, fill and dump counters, inactivity
// timer compare and the result register.
// ----------------------------------------------------------------------------
module kce_dp import kce_pkg::*; #(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire cfg_idx_t   cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic       poll_valid,
	input  wire kce_in_t    poll,
	output logic            res_valid,
	input  wire logic       res_stall,
	output kce_out_t        res,
	input  wire kce_cmd_t   cmd,
	output kce_sts_t        sts
);

	localparam int FILL_W = $clog2(CODE_LENGTH + 1);
	localparam int IDX_W  = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

	logic [15:0]       timeout_q;
	logic [7:0]        erase_q;
	logic [7:0]        enter_q;
	logic [31:0]       last_time_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        store_q [CODE_LENGTH];
	logic              res_valid_q;
	kce_out_t          res_q;
	logic [31:0]       elapsed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			erase_q   <= ERASE_RST;
			enter_q   <= ENTER_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TIMEOUT: timeout_q <= cfg_data[15:0];
				CFG_ERASE:   erase_q   <= cfg_data[7:0];
				CFG_ENTER:   enter_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			last_time_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			priority if (cmd.clear_fill) begin
				fill_q <= '0;
			end else if (cmd.add_key) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (cmd.del_key) begin
				fill_q <= fill_q - FILL_W'(1);
			end
			if (cmd.idx_start) begin
				idx_q <= '0;
			end else if (cmd.idx_step && !sts.emit_last) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.touch_time) begin
				last_time_q <= poll.time_now;
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// store entries are always written before a dump reads them
	always_ff @(posedge clk) begin
		if (cmd.add_key) begin
			store_q[fill_q[IDX_W-1:0]] <= poll.key;
		end
		if (cmd.out_load) begin
			res_q.screen     <= cmd.screen;
			res_q.code_valid <= cmd.out_code;
			res_q.code_byte  <= cmd.out_code ? store_q[idx_q] : 8'd0;
			res_q.last       <= cmd.out_last;
		end
	end

	assign elapsed = poll.time_now - last_time_q;

	always_comb begin
		sts.poll_valid = poll_valid;
		sts.key_none   = (poll.key == 8'd0);
		sts.key_erase  = (poll.key == erase_q);
		sts.key_enter  = (poll.key == enter_q);
		sts.expired    = (elapsed >= {16'd0, timeout_q});
		sts.full       = (fill_q == FILL_W'(CODE_LENGTH));
		sts.fill_one   = (fill_q == FILL_W'(1));
		sts.emit_last  = (idx_q == IDX_W'(CODE_LENGTH - 1));
		sts.out_free   = !res_valid_q || !res_stall;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire
